// ===== rtl/core/jse_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// jse_pkg
// Shared types, character codes and escape helpers for the JSON string
// escaper.
// ============================================================================
package jse_pkg;

    // Input item kinds, carried on the slave tuser
    typedef enum logic [1:0] {
        ACT_BEGIN = 2'd0,
        ACT_CHAR  = 2'd1,
        ACT_END   = 2'd2
    } action_t;

    // Characters that need escaping
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;

    // Escape code letters
    localparam logic [7:0] LET_B = 8'h62;
    localparam logic [7:0] LET_F = 8'h66;
    localparam logic [7:0] LET_N = 8'h6E;
    localparam logic [7:0] LET_R = 8'h72;
    localparam logic [7:0] LET_T = 8'h74;

    // Largest burst one item can cause: escaped backslash plus an escape pair
    localparam int unsigned BURST_MAX = 4;

    // Output bytes caused by one item; closes marks the final byte as the
    // closing quote
    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [2:0]                count;
        logic                      closes;
    } burst_t;

    // Code letter for a byte that needs escaping, zero when none is needed
    function automatic logic [7:0] escape_letter(input logic [7:0] c);
        logic [7:0] r;
        unique case (c)
            CH_QUOTE:  r = CH_QUOTE;
            CH_BSLASH: r = CH_BSLASH;
            CH_BS:     r = LET_B;
            CH_FF:     r = LET_F;
            CH_LF:     r = LET_N;
            CH_CR:     r = LET_R;
            CH_TAB:    r = LET_T;
            default:   r = 8'h00;
        endcase
        return r;
    endfunction

    // True for a byte that may follow a backslash as an existing escape
    function automatic logic is_code_char(input logic [7:0] c);
        return (c == CH_QUOTE) || (c == CH_BSLASH) || (c == LET_B) ||
               (c == LET_F) || (c == LET_N) || (c == LET_R) || (c == LET_T);
    endfunction

endpackage

// ===== rtl/core/json_string_escaper.sv =====
`timescale 1ns / 1ps
// ============================================================================
// json_string_escaper
// Streaming JSON string quoting and escaping, one text byte per beat.
// ============================================================================
// Usage:
//   Slave channel: tuser carries the item kind (begin, character, end), tdata
//   the character byte. Master channel: tdata is one byte of the quoted,
//   escaped text, tlast marks the final byte caused by an input beat, tuser
//   marks the closing quote.
//   A backslash is held back until the next item shows whether it already
//   starts an escape; that beat itself produces no output.
//   The first output byte of an item passes through the burst register and
//   then the output register.
//   Throughput: one input beat per cycle while each item yields one byte and
//   the receiver does not stall. An item yielding N bytes (up to 4) holds the
//   burst register until the output register has taken all N, one byte per
//   cycle while the receiver is ready; the slave tready drops until the last of those bytes moves out.
//   When the receiver stalls, the output register holds its beat and the
//   burst register fills, then tready drops; nothing is lost.
//   Reset clears the pending backslash and empties both registers.
// ============================================================================
module json_string_escaper
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_byte
    input  logic [1:0] s_axis_tuser,   // [1:0] action
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,
    output logic       m_axis_tuser    // [0] closes_string
);

    logic            accept;
    jse_pkg::burst_t burst;

    assign accept = s_axis_tvalid && s_axis_tready;

    // Item decode and pending backslash
    jse_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .action    (s_axis_tuser),
        .char_byte (s_axis_tdata),
        .burst     (burst)
    );

    // Burst register and output register
    jse_burst u_burst
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .burst      (burst),
        .in_ready   (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata),
        .out_last   (m_axis_tlast),
        .out_closes (m_axis_tuser)
    );

endmodule

// ===== rtl/core/jse_decode.sv =====
`timescale 1ns / 1ps
// ============================================================================
// jse_decode
// Turns one input item into its burst of output bytes and keeps the
// pending-backslash flag.
// ============================================================================
module jse_decode
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [1:0]      action,
    input  logic [7:0]      char_byte,
    output jse_pkg::burst_t burst
);

    logic       held_reg;
    logic       held_next;
    logic [7:0] esc;
    logic       code;

    // Burst build
    always_comb
    begin
        burst     = '0;
        held_next = held_reg;
        esc       = jse_pkg::escape_letter(char_byte);
        code      = jse_pkg::is_code_char(char_byte);
        unique case (action)
            jse_pkg::ACT_BEGIN:
            begin
                // a pending backslash is dropped silently
                burst.bytes[0] = jse_pkg::CH_QUOTE;
                burst.count    = 3'd1;
                held_next      = 1'b0;
            end
            jse_pkg::ACT_CHAR:
            begin
                if (held_reg && code)
                begin
                    // already escaped pair passes through
                    burst.bytes[0] = jse_pkg::CH_BSLASH;
                    burst.bytes[1] = char_byte;
                    burst.count    = 3'd2;
                    held_next      = 1'b0;
                end
                else
                begin
                    if (held_reg)
                    begin
                        burst.bytes[0] = jse_pkg::CH_BSLASH;
                        burst.bytes[1] = jse_pkg::CH_BSLASH;
                        burst.count    = 3'd2;
                        held_next      = 1'b0;
                    end
                    if (char_byte == jse_pkg::CH_BSLASH)
                    begin
                        held_next = 1'b1;
                    end
                    else if (esc != 8'h00)
                    begin
                        burst.bytes[burst.count[1:0]]        = jse_pkg::CH_BSLASH;
                        burst.bytes[burst.count[1:0] + 2'd1] = esc;
                        burst.count = 3'(burst.count + 3'd2);
                    end
                    else
                    begin
                        burst.bytes[burst.count[1:0]] = char_byte;
                        burst.count = 3'(burst.count + 3'd1);
                    end
                end
            end
            jse_pkg::ACT_END:
            begin
                if (held_reg)
                begin
                    burst.bytes[0] = jse_pkg::CH_BSLASH;
                    burst.bytes[1] = jse_pkg::CH_BSLASH;
                    burst.count    = 3'd2;
                end
                burst.bytes[burst.count[1:0]] = jse_pkg::CH_QUOTE;
                burst.count  = 3'(burst.count + 3'd1);
                burst.closes = 1'b1;
                held_next    = 1'b0;
            end
            default:
            begin
                // unused code: no output, flag kept
                held_next = held_reg;
            end
        endcase
    end

    // Pending-backslash flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
        end
        else if (accept)
        begin
            held_reg <= held_next;
        end
    end

endmodule

// ===== rtl/core/jse_burst.sv =====
`timescale 1ns / 1ps
// ============================================================================
// jse_burst
// Holds one item's burst and hands its bytes one per beat to the output
// register.
// ============================================================================
module jse_burst
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  jse_pkg::burst_t burst,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            out_last,
    output logic            out_closes
);

    jse_pkg::burst_t burst_reg;
    logic            busy_reg;
    logic [1:0]      idx_reg;
    logic            out_valid_reg;
    logic [7:0]      out_byte_reg;
    logic            out_last_reg;
    logic            out_closes_reg;

    logic            load_in;
    logic            out_load;
    logic            is_final;
    logic            burst_done;

    // Handshake between burst and output register
    assign load_in    = accept && (burst.count != 3'd0);
    assign out_load   = busy_reg && (!out_valid_reg || out_ready);
    assign is_final   = ({1'b0, idx_reg} == 3'(burst_reg.count - 3'd1));
    assign burst_done = out_load && is_final;
    assign in_ready   = !busy_reg || burst_done;

    // Burst control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            if (load_in)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= 2'd0;
            end
            else if (out_load)
            begin
                busy_reg <= !is_final;
                idx_reg  <= 2'(idx_reg + 2'd1);
            end
        end
    end

    // Burst payload
    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            burst_reg <= burst;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_byte_reg   <= burst_reg.bytes[idx_reg];
            out_last_reg   <= is_final;
            out_closes_reg <= is_final && burst_reg.closes;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign out_last   = out_last_reg;
    assign out_closes = out_closes_reg;

endmodule

// ===== rtl/core/jse_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// jse_checker
// Port-level checks on the JSON string escaper output stream.
// ============================================================================
module jse_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic [1:0] s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       m_axis_tuser
);

    // Waiting input beat holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=>
        s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
        else $error("input beat changed while waiting");

    // Stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
        $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    // Closing mark only on a final quote
    a_close_quote: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
        m_axis_tlast && (m_axis_tdata == jse_pkg::CH_QUOTE))
        else $error("closing mark on a byte that is not the final quote");

    // Every byte before the last of an item is a backslash
    a_inner_bslash: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> (m_axis_tdata == jse_pkg::CH_BSLASH))
        else $error("non-final byte of an item is not a backslash");

endmodule

bind json_string_escaper jse_checker u_jse_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== test/json_string_escaper_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// json_string_escaper_tb
// Self-checking bench for the streaming JSON string escaper. Strings go in
// as begin / character / end beats; a local escaping model predicts every
// output beat, and a checker compares each one field by field against the
// oldest prediction. Directed strings cover byte extremes, every escape and
// each pending-backslash case; random strings follow under several
// sender-idle and receiver-stall mixes.
// ============================================================================
module json_string_escaper_tb;

    // Action code the block must ignore
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // One expected output beat
    typedef struct {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       closes_string;
    } text_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] char_byte
    logic [1:0] s_axis_tuser = jse_pkg::ACT_BEGIN;   // [1:0] action
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;   // [7:0] out_byte
    logic       m_axis_tlast;
    logic       m_axis_tuser;   // [0] closes_string

    // Escaped text still owed by the block, oldest first
    text_beat_t  escaped_text_q[$];
    logic        pending_bslash = 1'b0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count = 0;

    json_string_escaper uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 clk = ~clk;

    // Escape model: push the beats one accepted item produces
    task automatic predict_escape(input logic [1:0] act, input logic [7:0] ch);
        logic [7:0] burst[$];
        logic       closes;
        logic [7:0] letter;
        text_beat_t beat;
        closes = 1'b0;
        letter = 8'h00;
        case (act)
            jse_pkg::ACT_BEGIN:
            begin
                // a held backslash is simply dropped
                pending_bslash = 1'b0;
                burst.push_back(jse_pkg::CH_QUOTE);
            end
            jse_pkg::ACT_CHAR:
            begin
                if (pending_bslash && (ch inside {jse_pkg::CH_QUOTE, jse_pkg::CH_BSLASH,
                                                  jse_pkg::LET_B, jse_pkg::LET_F,
                                                  jse_pkg::LET_N, jse_pkg::LET_R,
                                                  jse_pkg::LET_T}))
                begin
                    // already escaped: pair goes through as is
                    pending_bslash = 1'b0;
                    burst.push_back(jse_pkg::CH_BSLASH);
                    burst.push_back(ch);
                end
                else
                begin
                    if (pending_bslash)
                    begin
                        pending_bslash = 1'b0;
                        burst.push_back(jse_pkg::CH_BSLASH);
                        burst.push_back(jse_pkg::CH_BSLASH);
                    end
                    case (ch)
                        jse_pkg::CH_QUOTE: letter = jse_pkg::CH_QUOTE;
                        jse_pkg::CH_BS:    letter = jse_pkg::LET_B;
                        jse_pkg::CH_FF:    letter = jse_pkg::LET_F;
                        jse_pkg::CH_LF:    letter = jse_pkg::LET_N;
                        jse_pkg::CH_CR:    letter = jse_pkg::LET_R;
                        jse_pkg::CH_TAB:   letter = jse_pkg::LET_T;
                        default:           letter = 8'h00;
                    endcase
                    if (ch == jse_pkg::CH_BSLASH)
                        pending_bslash = 1'b1;
                    else if (letter != 8'h00)
                    begin
                        burst.push_back(jse_pkg::CH_BSLASH);
                        burst.push_back(letter);
                    end
                    else
                        burst.push_back(ch);
                end
            end
            jse_pkg::ACT_END:
            begin
                if (pending_bslash)
                begin
                    pending_bslash = 1'b0;
                    burst.push_back(jse_pkg::CH_BSLASH);
                    burst.push_back(jse_pkg::CH_BSLASH);
                end
                burst.push_back(jse_pkg::CH_QUOTE);
                closes = 1'b1;
            end
            default:
            begin
                // unused code: no output, state kept
            end
        endcase
        foreach (burst[i])
        begin
            beat.out_byte      = burst[i];
            beat.last_of_run   = (i == burst.size() - 1);
            beat.closes_string = closes && (i == burst.size() - 1);
            escaped_text_q.push_back(beat);
        end
    endtask

    // Send one beat; entered and left at a falling edge
    task automatic send_item(input logic [1:0] act, input logic [7:0] ch);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= act;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_escape(act, ch);
        @(negedge clk);
    endtask

    // Receiver back-pressure, changed at the falling edge
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Output checker
    always @(posedge clk)
    begin
        text_beat_t exp_beat;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (escaped_text_q.size() == 0)
            begin
                $error("unexpected beat: out_byte %h last_of_run %b closes_string %b",
                       m_axis_tdata, m_axis_tlast, m_axis_tuser);
                error_count++;
            end
            else
            begin
                exp_beat = escaped_text_q.pop_front();
                if (m_axis_tdata !== exp_beat.out_byte)
                begin
                    $error("out_byte: expected %h, got %h",
                           exp_beat.out_byte, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tlast !== exp_beat.last_of_run)
                begin
                    $error("last_of_run: expected %b, got %b",
                           exp_beat.last_of_run, m_axis_tlast);
                    error_count++;
                end
                if (m_axis_tuser !== exp_beat.closes_string)
                begin
                    $error("closes_string: expected %b, got %b",
                           exp_beat.closes_string, m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    // Byte extremes and the escape of every special character
    task automatic test_plain_and_escapes();
        send_item(jse_pkg::ACT_BEGIN, 8'hFF);
        send_item(jse_pkg::ACT_CHAR, 8'h00);
        send_item(jse_pkg::ACT_CHAR, 8'hFF);
        send_item(jse_pkg::ACT_CHAR, jse_pkg::CH_QUOTE);
        send_item(jse_pkg::ACT_CHAR, jse_pkg::CH_BS);
        send_item(jse_pkg::ACT_CHAR, jse_pkg::CH_FF);
        send_item(jse_pkg::ACT_CHAR, jse_pkg::CH_LF);
        send_item(jse_pkg::ACT_CHAR, jse_pkg::CH_CR);
        send_item(jse_pkg::ACT_CHAR, jse_pkg::CH_TAB);
    endtask

    // Pending backslash resolved by each kind of follower
    task automatic test_held_backslash();
        send_item(jse_pkg::ACT_CHAR, jse_pkg::CH_BSLASH);
        send_item(jse_pkg::ACT_CHAR, jse_pkg::LET_N);      // existing escape passes
        send_item(jse_pkg::ACT_CHAR, jse_pkg::CH_BSLASH);
        send_item(jse_pkg::ACT_CHAR, 8'h41);               // plain byte after backslash
        send_item(jse_pkg::ACT_CHAR, jse_pkg::CH_BSLASH);
        send_item(jse_pkg::ACT_CHAR, jse_pkg::CH_BSLASH);  // double backslash passes
        send_item(jse_pkg::ACT_CHAR, jse_pkg::CH_BSLASH);
        send_item(jse_pkg::ACT_CHAR, jse_pkg::CH_LF);      // widest burst: four bytes
        send_item(jse_pkg::ACT_CHAR, jse_pkg::CH_BSLASH);
        send_item(jse_pkg::ACT_END, 8'h00);                // backslash before closing quote
        // begin drops the held backslash
        send_item(jse_pkg::ACT_BEGIN, 8'h00);
        send_item(jse_pkg::ACT_CHAR, jse_pkg::CH_BSLASH);
        send_item(jse_pkg::ACT_BEGIN, 8'hA5);
    endtask

    // Unused action leaves the held backslash alone
    task automatic test_unused_action();
        send_item(jse_pkg::ACT_CHAR, jse_pkg::CH_BSLASH);
        send_item(ACT_UNUSED, 8'hFF);
        send_item(jse_pkg::ACT_CHAR, jse_pkg::LET_T);
        send_item(jse_pkg::ACT_END, 8'h5A);
    endtask

    // Byte biased toward backslashes, code letters and control characters
    function automatic logic [7:0] pick_text_byte();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 25)
            return jse_pkg::CH_BSLASH;
        else if (r < 45)
        begin
            case ($urandom_range(5))
                0: return jse_pkg::CH_QUOTE;
                1: return jse_pkg::LET_B;
                2: return jse_pkg::LET_F;
                3: return jse_pkg::LET_N;
                4: return jse_pkg::LET_R;
                default: return jse_pkg::LET_T;
            endcase
        end
        else if (r < 58)
            return 8'($urandom_range(8, 13));
        else
            return 8'($urandom_range(255));
    endfunction

    // Random strings, with some stray and unused beats mixed in
    task automatic test_random_text(input int unsigned idle_pct, input int unsigned stall_pct,
                                    input int unsigned item_count);
        int unsigned sent;
        int unsigned kind;
        int unsigned len;
        sent = 0;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent < item_count)
        begin
            kind = $urandom_range(99);
            if (kind < 85)
            begin
                len = $urandom_range(0, 8);
                send_item(jse_pkg::ACT_BEGIN, 8'($urandom_range(255)));
                repeat (len)
                    send_item(jse_pkg::ACT_CHAR, pick_text_byte());
                send_item(jse_pkg::ACT_END, 8'($urandom_range(255)));
                sent += len + 2;
            end
            else if (kind < 91)
                send_item(ACT_UNUSED, 8'($urandom_range(255)));
            else if (kind < 96)
            begin
                send_item(jse_pkg::ACT_END, 8'($urandom_range(255)));
                sent++;
            end
            else
            begin
                send_item(jse_pkg::ACT_BEGIN, 8'($urandom_range(255)));
                sent++;
            end
        end
    endtask

    // Stimulus sequence and final verdict
    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_plain_and_escapes();
        test_held_backslash();
        test_unused_action();
        test_random_text(0, 0, 20);
        test_random_text(51, 0, 20);
        test_random_text(0, 51, 20);
        test_random_text(29, 29, 20);

        s_axis_tvalid <= 1'b0;
        while (escaped_text_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        if (error_count == 0)
            $display("json_string_escaper verification clean");
        else
            $display("json_string_escaper verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("json_string_escaper verification failed");
        $finish;
    end

endmodule
